### src/battery_voltage_gauge_macros.svh
// Assertion macros for the battery voltage gauge.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef BATTERY_VOLTAGE_GAUGE_MACROS_SVH
`define BATTERY_VOLTAGE_GAUGE_MACROS_SVH

`define BVG_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("battery_voltage_gauge: same-cycle check failed");

`define BVG_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("battery_voltage_gauge: next-cycle check failed");

`endif

### src/bvg_pkg.sv
// Shared constants, types and codes of the battery voltage gauge.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bvg_pkg;

    localparam int WINDOW     = 10;
    localparam int ADC_BITS   = 12;
    localparam int MV_W       = 14;
    localparam int PCT_W      = 10;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam int CODE_MAX  = (1 << ADC_BITS) - 1;
    localparam int PCT_FULL  = 1000;
    localparam int SUM_W     = $clog2(WINDOW * ((1 << MV_W) - 1) + 1);
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int PROD_W    = ADC_BITS + MV_W;
    localparam int PCT_NUM_W = MV_W + $clog2(PCT_FULL + 1);

    localparam int DIV_N_A   = (PROD_W > SUM_W) ? PROD_W : SUM_W;
    localparam int DIV_N_W   = (DIV_N_A > PCT_NUM_W) ? DIV_N_A : PCT_NUM_W;
    localparam int DEN_A     = (MV_W > ADC_BITS) ? MV_W : ADC_BITS;
    localparam int DEN_W     = (DEN_A > CNT_W) ? DEN_A : CNT_W;
    localparam int DIV_STEPS = (DIV_N_W + 1) / 2;
    localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [MV_W-1:0]  RESET_FULL_SCALE = 14'd10560;
    localparam logic [MV_W-1:0]  RESET_EMPTY_MV   = 14'd3000;
    localparam logic [MV_W-1:0]  RESET_FULL_MV    = 14'd4200;
    localparam logic [PCT_W-1:0] RESET_LOW        = 10'd200;
    localparam logic [PCT_W-1:0] RESET_MEDIUM     = 10'd500;
    localparam logic [PCT_W-1:0] RESET_GOOD       = 10'd800;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GOOD       = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_CRITICAL  = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_LOW       = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_MEDIUM    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_GOOD      = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_EXCELLENT = 3'd4;

    typedef enum logic [1:0] {
        DIV_SCALE,
        DIV_MEAN,
        DIV_PCT
    } div_sel_t;

    typedef struct packed {
        logic     capture;
        logic     div_start;
        div_sel_t div_sel;
        logic     ring_update;
        logic     mean_load;
        logic     pct_load_div;
        logic     pct_load_direct;
        logic     out_load;
    } bvg_cmd_t;

    typedef struct packed {
        logic code_zero;
        logic div_done;
        logic pct_direct;
    } bvg_status_t;

endpackage

`default_nettype wire

### src/bvg_divider.sv
// Unsigned restoring divider that retires two quotient bits per cycle.
// Depends on bvg_pkg for operand widths and the step count.
`default_nettype none

module bvg_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bvg_pkg::DIV_N_W-1:0] dividend,
    input  logic [bvg_pkg::DEN_W-1:0]   divisor,
    output logic                        done,
    output logic [bvg_pkg::DIV_N_W-1:0] quotient
);

    localparam int NUM_W = 2 * bvg_pkg::DIV_STEPS;

    logic                            busy_reg;
    logic                            done_reg;
    logic [bvg_pkg::DIV_CNT_W-1:0]   count_reg;
    logic [bvg_pkg::DEN_W-1:0]       rem_reg;
    logic [bvg_pkg::DEN_W-1:0]       rem_next;
    logic [bvg_pkg::DEN_W-1:0]       den_reg;
    logic [NUM_W-1:0]                num_reg;
    logic [NUM_W-1:0]                num_next;
    logic [bvg_pkg::DEN_W:0]         trial;
    logic                            qbit;

    always_comb
    begin
        rem_next = rem_reg;
        num_next = num_reg;
        trial    = '0;
        qbit     = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            trial = {rem_next, num_next[NUM_W-1]};
            qbit  = (trial >= {1'b0, den_reg});
            if (qbit)
            begin
                trial = trial - {1'b0, den_reg};
            end
            rem_next = trial[bvg_pkg::DEN_W-1:0];
            num_next = {num_next[NUM_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= bvg_pkg::DIV_CNT_W'(bvg_pkg::DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= divisor;
            num_reg <= NUM_W'(dividend);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg[bvg_pkg::DIV_N_W-1:0];

endmodule

`default_nettype wire

### src/bvg_datapath.sv
// Datapath of the battery voltage gauge: registers, sample ring, running sum,
// shared divider and result registers. Depends on bvg_pkg and bvg_divider.
`default_nettype none

module bvg_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bvg_pkg::bvg_cmd_t               cmd,
    output bvg_pkg::bvg_status_t            stat,
    input  logic                            cfg_write,
    input  logic [bvg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bvg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [bvg_pkg::ADC_BITS-1:0]    raw_code,
    output logic                            read_failed,
    output logic [bvg_pkg::MV_W-1:0]        filtered_mv,
    output logic [bvg_pkg::PCT_W-1:0]       percent_tenths,
    output logic [bvg_pkg::STATUS_W-1:0]    status
);

    logic [bvg_pkg::MV_W-1:0]      full_scale_reg;
    logic [bvg_pkg::MV_W-1:0]      empty_mv_reg;
    logic [bvg_pkg::MV_W-1:0]      full_mv_reg;
    logic [bvg_pkg::PCT_W-1:0]     low_reg;
    logic [bvg_pkg::PCT_W-1:0]     medium_reg;
    logic [bvg_pkg::PCT_W-1:0]     good_reg;

    logic [bvg_pkg::ADC_BITS-1:0]  code_reg;
    logic [bvg_pkg::MV_W-1:0]      ring_reg [bvg_pkg::WINDOW];
    logic [bvg_pkg::SLOT_W-1:0]    slot_reg;
    logic                          ring_full_reg;
    logic [bvg_pkg::SUM_W-1:0]     sum_reg;
    logic [bvg_pkg::MV_W-1:0]      mean_reg;
    logic [bvg_pkg::PCT_W-1:0]     pct_reg;

    logic                          read_failed_reg;
    logic [bvg_pkg::MV_W-1:0]      filtered_reg;
    logic [bvg_pkg::PCT_W-1:0]     percent_reg;
    logic [bvg_pkg::STATUS_W-1:0]  status_reg;

    logic [bvg_pkg::PROD_W-1:0]    product;
    logic [bvg_pkg::MV_W-1:0]      diff_mv;
    logic [bvg_pkg::PCT_NUM_W-1:0] pct_num;
    logic [bvg_pkg::CNT_W-1:0]     sample_count;
    logic [bvg_pkg::DIV_N_W-1:0]   dividend;
    logic [bvg_pkg::DEN_W-1:0]     divisor;
    logic                          div_done;
    logic [bvg_pkg::DIV_N_W-1:0]   quotient;
    logic [bvg_pkg::MV_W-1:0]      mv_new;
    logic [bvg_pkg::SUM_W-1:0]     sum_drop;
    logic [bvg_pkg::STATUS_W-1:0]  status_calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= bvg_pkg::RESET_FULL_SCALE;
            empty_mv_reg   <= bvg_pkg::RESET_EMPTY_MV;
            full_mv_reg    <= bvg_pkg::RESET_FULL_MV;
            low_reg        <= bvg_pkg::RESET_LOW;
            medium_reg     <= bvg_pkg::RESET_MEDIUM;
            good_reg       <= bvg_pkg::RESET_GOOD;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bvg_pkg::REG_FULL_SCALE: full_scale_reg <= cfg_data[bvg_pkg::MV_W-1:0];
                bvg_pkg::REG_EMPTY_MV:   empty_mv_reg   <= cfg_data[bvg_pkg::MV_W-1:0];
                bvg_pkg::REG_FULL_MV:    full_mv_reg    <= cfg_data[bvg_pkg::MV_W-1:0];
                bvg_pkg::REG_LOW:        low_reg        <= cfg_data[bvg_pkg::PCT_W-1:0];
                bvg_pkg::REG_MEDIUM:     medium_reg     <= cfg_data[bvg_pkg::PCT_W-1:0];
                bvg_pkg::REG_GOOD:       good_reg       <= cfg_data[bvg_pkg::PCT_W-1:0];
                default:                 ;
            endcase
        end
    end

    assign product      = bvg_pkg::PROD_W'(code_reg) * bvg_pkg::PROD_W'(full_scale_reg);
    assign diff_mv      = mean_reg - empty_mv_reg;
    assign pct_num      = bvg_pkg::PCT_NUM_W'(diff_mv)
                        * bvg_pkg::PCT_NUM_W'(bvg_pkg::PCT_FULL);
    assign sample_count = ring_full_reg ? bvg_pkg::CNT_W'(bvg_pkg::WINDOW)
                                        : bvg_pkg::CNT_W'(slot_reg);

    always_comb
    begin
        unique case (cmd.div_sel)
            bvg_pkg::DIV_SCALE:
            begin
                dividend = bvg_pkg::DIV_N_W'(product);
                divisor  = bvg_pkg::DEN_W'(bvg_pkg::CODE_MAX);
            end
            bvg_pkg::DIV_MEAN:
            begin
                dividend = bvg_pkg::DIV_N_W'(sum_reg);
                divisor  = bvg_pkg::DEN_W'(sample_count);
            end
            bvg_pkg::DIV_PCT:
            begin
                dividend = bvg_pkg::DIV_N_W'(pct_num);
                divisor  = bvg_pkg::DEN_W'(full_mv_reg - empty_mv_reg);
            end
            default:
            begin
                dividend = '0;
                divisor  = '0;
            end
        endcase
    end

    bvg_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign mv_new   = quotient[bvg_pkg::MV_W-1:0];
    assign sum_drop = ring_full_reg ? bvg_pkg::SUM_W'(ring_reg[slot_reg]) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            code_reg <= raw_code;
        end
        if (cmd.ring_update)
        begin
            ring_reg[slot_reg] <= mv_new;
        end
        if (cmd.mean_load)
        begin
            mean_reg <= mv_new;
        end
        if (cmd.pct_load_direct)
        begin
            pct_reg <= (mean_reg >= full_mv_reg) ? bvg_pkg::PCT_W'(bvg_pkg::PCT_FULL) : '0;
        end
        else if (cmd.pct_load_div)
        begin
            pct_reg <= quotient[bvg_pkg::PCT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            ring_full_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else if (cmd.ring_update)
        begin
            sum_reg <= sum_reg - sum_drop + bvg_pkg::SUM_W'(mv_new);
            if (slot_reg == bvg_pkg::SLOT_W'(bvg_pkg::WINDOW - 1))
            begin
                slot_reg      <= '0;
                ring_full_reg <= 1'b1;
            end
            else
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (mean_reg < empty_mv_reg)
        begin
            status_calc = bvg_pkg::STATUS_CRITICAL;
        end
        else if (pct_reg < low_reg)
        begin
            status_calc = bvg_pkg::STATUS_LOW;
        end
        else if (pct_reg < medium_reg)
        begin
            status_calc = bvg_pkg::STATUS_MEDIUM;
        end
        else if (pct_reg < good_reg)
        begin
            status_calc = bvg_pkg::STATUS_GOOD;
        end
        else
        begin
            status_calc = bvg_pkg::STATUS_EXCELLENT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (code_reg == '0)
            begin
                read_failed_reg <= 1'b1;
                filtered_reg    <= '0;
                percent_reg     <= '0;
                status_reg      <= bvg_pkg::STATUS_CRITICAL;
            end
            else
            begin
                read_failed_reg <= 1'b0;
                filtered_reg    <= mean_reg;
                percent_reg     <= pct_reg;
                status_reg      <= status_calc;
            end
        end
    end

    assign stat.code_zero  = (code_reg == '0);
    assign stat.div_done   = div_done;
    assign stat.pct_direct = (mean_reg >= full_mv_reg) || (mean_reg <= empty_mv_reg);

    assign read_failed    = read_failed_reg;
    assign filtered_mv    = filtered_reg;
    assign percent_tenths = percent_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire

### src/bvg_ctrl.sv
// Controller of the battery voltage gauge: sequences one word through scaling,
// averaging and percentage steps and owns both handshakes. Depends on bvg_pkg.
`default_nettype none

module bvg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 code_valid,
    output logic                 code_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  bvg_pkg::bvg_status_t stat,
    output bvg_pkg::bvg_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCALE,
        S_MEAN_GO,
        S_MEAN,
        S_PCT_GO,
        S_PCT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   valid_reg;
    logic   valid_next;
    logic   out_free;

    assign out_free = !valid_reg || !result_stall;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = bvg_pkg::DIV_SCALE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (code_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.code_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = bvg_pkg::DIV_SCALE;
                    state_next    = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (stat.div_done)
                begin
                    cmd.ring_update = 1'b1;
                    state_next      = S_MEAN_GO;
                end
            end
            S_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = bvg_pkg::DIV_MEAN;
                state_next    = S_MEAN;
            end
            S_MEAN:
            begin
                if (stat.div_done)
                begin
                    cmd.mean_load = 1'b1;
                    state_next    = S_PCT_GO;
                end
            end
            S_PCT_GO:
            begin
                if (stat.pct_direct)
                begin
                    cmd.pct_load_direct = 1'b1;
                    state_next          = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = bvg_pkg::DIV_PCT;
                    state_next    = S_PCT;
                end
            end
            S_PCT:
            begin
                if (stat.div_done)
                begin
                    cmd.pct_load_div = 1'b1;
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
            valid_reg <= valid_next;
        end
    end

    assign code_stall   = stall_reg;
    assign result_valid = valid_reg;

endmodule

`default_nettype wire

### src/battery_voltage_gauge.sv
// Battery voltage gauge: takes one ADC code word at a time and returns one
// result word with the moving-average voltage, a charge estimate in tenths of
// a percent and a five-level status. A code of zero gives a failed-read word
// and leaves the average alone. Any other code passes through up to three
// divisions (scaling to millivolts, the mean over the ring and the
// percentage) on one shared divider that retires two quotient bits a cycle;
// the percentage division is skipped when the mean lies at or beyond the
// empty or full voltage. The next code word is taken as soon as the previous
// result sits in the output register. Configuration writes go to index 0 to
// 5 and are meant for an idle block.
// Depends on bvg_pkg, bvg_ctrl, bvg_datapath and the assertion macro header.
`default_nettype none

module battery_voltage_gauge (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [bvg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bvg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            code_valid,
    output logic                            code_stall,
    input  logic [bvg_pkg::ADC_BITS-1:0]    raw_code,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            read_failed,
    output logic [bvg_pkg::MV_W-1:0]        filtered_mv,
    output logic [bvg_pkg::PCT_W-1:0]       percent_tenths,
    output logic [bvg_pkg::STATUS_W-1:0]    status
);

    bvg_pkg::bvg_cmd_t    cmd;
    bvg_pkg::bvg_status_t stat;

    bvg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .code_valid   (code_valid),
        .code_stall   (code_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    bvg_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .raw_code       (raw_code),
        .read_failed    (read_failed),
        .filtered_mv    (filtered_mv),
        .percent_tenths (percent_tenths),
        .status         (status)
    );

`include "battery_voltage_gauge_macros.svh"

    `BVG_ASSERT_IMP(a_failed_word_zero, result_valid && read_failed, filtered_mv == '0 && percent_tenths == '0 && status == bvg_pkg::STATUS_CRITICAL)
    `BVG_ASSERT_IMP(a_result_in_range, result_valid && !read_failed, percent_tenths <= bvg_pkg::PCT_W'(bvg_pkg::PCT_FULL) && status <= bvg_pkg::STATUS_EXCELLENT)
    `BVG_ASSERT_NEXT(a_busy_after_accept, code_valid && !code_stall, code_stall)

endmodule

`default_nettype wire
